@@ design/wtps_pkg.sv @@
// ----------------------------------------------------------------------------
// wtps_pkg
// Shared types and constants for the whitespace tolerant pattern search unit.
// ----------------------------------------------------------------------------
package wtps_pkg;

    // Pattern geometry
    localparam int MAX_PATTERN = 16;
    localparam int LEVELS      = 16;
    localparam int LEN_W       = 5;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LINE_W  = 24;
    localparam int OFFS_W  = 32;
    localparam int COUNT_W = 32;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    // Register indexes (taken from paddr[4:3])
    localparam logic [1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [1:0] REG_PAT_LEN  = 2'd2;

    // Gap characters
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    // Output queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One result word
    typedef struct packed {
        logic [LINE_W-1:0]  line;
        logic [OFFS_W-1:0]  offset;
        logic [COUNT_W-1:0] total;
    } t_result;

    // Output queue status
    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  not_empty;
    } t_fifo_status;

endpackage

@@ design/wtps_out_fifo.sv @@
// ----------------------------------------------------------------------------
// wtps_out_fifo
// Small result queue that decouples the search logic from output stalls.
// ----------------------------------------------------------------------------
module wtps_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wtps_pkg::t_result     i_data,
    input  logic                  i_pop,
    output wtps_pkg::t_result     o_data,
    output wtps_pkg::t_fifo_status o_status
);

    wtps_pkg::t_result                    r_mem [wtps_pkg::FIFO_DEPTH];
    logic [wtps_pkg::FIFO_PTR_W-1:0]      r_wr_ptr;
    logic [wtps_pkg::FIFO_PTR_W-1:0]      r_rd_ptr;
    logic [wtps_pkg::FIFO_CNT_W-1:0]      r_count;
    logic                                 w_pop;

    localparam logic [wtps_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        wtps_pkg::FIFO_PTR_W'(wtps_pkg::FIFO_DEPTH - 1);

    // pop only a held word
    assign w_pop = i_pop && (r_count != '0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data             = r_mem[r_rd_ptr];
    assign o_status.count     = r_count;
    assign o_status.not_empty = (r_count != '0);

endmodule

@@ design/whitespace_tolerant_pattern_search_unit.sv @@
// ----------------------------------------------------------------------------
// whitespace_tolerant_pattern_search_unit
// Streaming pattern search that tolerates space, tab and line feed between
// pattern characters, reporting line, offset and running count per match.
// ----------------------------------------------------------------------------
// Takes one text byte per clock cycle while the input is not stalled. A byte
// lands in an input register and is resolved against all fifteen attempt
// trackers in parallel in the following cycle; a match word is written from
// that step into a three word result queue that drives the output. The input
// is stalled only while that queue plus the input register hold three words.
// The pattern is written through the APB port at byte addresses 0, 8 and 16;
// the user must write it only while no text is in flight, and the block itself
// leaves this to the user.
module whitespace_tolerant_pattern_search_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // text input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [wtps_pkg::BYTE_W-1:0]         i_text_byte,
    input  logic                                i_end_of_text,
    // match output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [wtps_pkg::LINE_W-1:0]         o_match_line,
    output logic [wtps_pkg::OFFS_W-1:0]         o_match_offset,
    output logic [wtps_pkg::COUNT_W-1:0]        o_matches_so_far,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wtps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wtps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wtps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int LV = wtps_pkg::LEVELS;
    localparam logic [wtps_pkg::LINE_W-1:0]  LINE_MAX  = '1;
    localparam logic [wtps_pkg::OFFS_W-1:0]  OFFS_MAX  = '1;
    localparam logic [wtps_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [63:0]                      r_pat_low;
    logic [63:0]                      r_pat_high;
    logic [wtps_pkg::LEN_W-1:0]       r_pat_len;

    // input register
    logic                             r_in_valid;
    logic [wtps_pkg::BYTE_W-1:0]      r_in_byte;
    logic                             r_in_eot;

    // text state
    logic [LV-1:1]                    r_live;
    logic [wtps_pkg::LINE_W-1:0]      r_att_line [1:LV-1];
    logic [wtps_pkg::OFFS_W-1:0]      r_att_offs [1:LV-1];
    logic [wtps_pkg::OFFS_W-1:0]      r_byte_pos;
    logic [wtps_pkg::LINE_W-1:0]      r_line_cnt;
    logic [wtps_pkg::COUNT_W-1:0]     r_match_total;

    // next values
    logic [LV-1:1]                    n_live;
    logic [wtps_pkg::LINE_W-1:0]      n_att_line [1:LV-1];
    logic [wtps_pkg::OFFS_W-1:0]      n_att_offs [1:LV-1];
    logic [wtps_pkg::OFFS_W-1:0]      n_byte_pos;
    logic [wtps_pkg::LINE_W-1:0]      n_line_cnt;
    logic [wtps_pkg::COUNT_W-1:0]     n_match_total;

    logic                             w_done;
    logic [wtps_pkg::LINE_W-1:0]      w_res_line;
    logic [wtps_pkg::OFFS_W-1:0]      w_res_offs;
    wtps_pkg::t_result                w_result;
    wtps_pkg::t_result                w_fifo_data;
    wtps_pkg::t_fifo_status           w_fifo_st;
    logic                             w_in_accept;
    logic                             w_out_pop;
    logic                             w_cfg_wr;
    logic [127:0]                     w_pat;
    logic [wtps_pkg::LEN_W-1:0]       w_len;
    logic [wtps_pkg::LINE_W-1:0]      w_cur_line;
    logic                             w_gap;
    logic                             w_start;
    logic [LV-1:0]                    w_hit;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[4:3])
            wtps_pkg::REG_PAT_LOW:  prdata = r_pat_low;
            wtps_pkg::REG_PAT_HIGH: prdata = r_pat_high;
            wtps_pkg::REG_PAT_LEN:  prdata = {{(wtps_pkg::APB_DATA_W-wtps_pkg::LEN_W){1'b0}},
                                              r_pat_len};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= wtps_pkg::LEN_W'(1);
        end else if (w_cfg_wr) begin
            unique case (paddr[4:3])
                wtps_pkg::REG_PAT_LOW:  r_pat_low  <= pwdata;
                wtps_pkg::REG_PAT_HIGH: r_pat_high <= pwdata;
                wtps_pkg::REG_PAT_LEN:  r_pat_len  <= pwdata[wtps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input handshake: stall once queue and input register hold three words
    // ------------------------------------------------------------------
    assign o_in_stall = ({1'b0, w_fifo_st.count} + {{wtps_pkg::FIFO_CNT_W{1'b0}}, r_in_valid})
                        >= (wtps_pkg::FIFO_CNT_W+1)'(wtps_pkg::FIFO_DEPTH);
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    // ------------------------------------------------------------------
    // per-byte search step
    // ------------------------------------------------------------------
    assign w_pat = {r_pat_high, r_pat_low};

    // effective length, clamped to 1..MAX_PATTERN
    always_comb begin
        if (r_pat_len == '0) begin
            w_len = wtps_pkg::LEN_W'(1);
        end else if (r_pat_len > wtps_pkg::LEN_W'(wtps_pkg::MAX_PATTERN)) begin
            w_len = wtps_pkg::LEN_W'(wtps_pkg::MAX_PATTERN);
        end else begin
            w_len = r_pat_len;
        end
    end

    assign w_gap = (r_in_byte == wtps_pkg::CH_SPACE) || (r_in_byte == wtps_pkg::CH_TAB) ||
                   (r_in_byte == wtps_pkg::CH_LF);

    // byte equals pattern byte k
    always_comb begin
        for (int k = 0; k < LV; k++) begin
            w_hit[k] = (r_in_byte == w_pat[8*k +: 8]);
        end
    end

    assign w_start    = w_hit[0];
    assign n_byte_pos = (r_byte_pos == OFFS_MAX) ? r_byte_pos : r_byte_pos + 1'b1;
    assign w_cur_line = (r_line_cnt == LINE_MAX) ? r_line_cnt : r_line_cnt + 1'b1;

    // line count moves on a line feed that opens no attempt
    assign n_line_cnt = (!w_start && (r_in_byte == wtps_pkg::CH_LF) && (r_line_cnt != LINE_MAX))
                        ? r_line_cnt + 1'b1 : r_line_cnt;

    // tracker levels: first candidate wins unless the second starts earlier
    always_comb begin
        logic                        f_v;
        logic                        s_v;
        logic [wtps_pkg::LINE_W-1:0] f_line;
        logic [wtps_pkg::LINE_W-1:0] s_line;
        logic [wtps_pkg::OFFS_W-1:0] f_offs;
        logic [wtps_pkg::OFFS_W-1:0] s_offs;
        logic                        stay;
        f_v    = 1'b0;
        s_v    = 1'b0;
        f_line = '0;
        s_line = '0;
        f_offs = '0;
        s_offs = '0;
        stay   = 1'b0;
        for (int j = 1; j < LV; j++) begin
            stay = r_live[j] && (wtps_pkg::LEN_W'(j) < w_len) && !w_hit[j] && w_gap;
            if (j == 1) begin
                // held attempt first, new start second
                f_v    = stay;
                f_line = r_att_line[j];
                f_offs = r_att_offs[j];
                s_v    = w_start && (w_len > wtps_pkg::LEN_W'(1));
                s_line = w_cur_line;
                s_offs = n_byte_pos;
            end else begin
                // advancing attempt first, held attempt second
                f_v    = r_live[j-1] && w_hit[j-1] && (wtps_pkg::LEN_W'(j) < w_len);
                f_line = r_att_line[j-1];
                f_offs = r_att_offs[j-1];
                s_v    = stay;
                s_line = r_att_line[j];
                s_offs = r_att_offs[j];
            end
            if (f_v && !(s_v && (s_offs < f_offs))) begin
                n_live[j]     = 1'b1;
                n_att_line[j] = f_line;
                n_att_offs[j] = f_offs;
            end else begin
                n_live[j]     = s_v;
                n_att_line[j] = s_line;
                n_att_offs[j] = s_offs;
            end
        end
    end

    // done when level len-1 takes the last byte, or on a start if len is 1
    always_comb begin
        w_done     = 1'b0;
        w_res_line = '0;
        w_res_offs = '0;
        if (w_start && (w_len == wtps_pkg::LEN_W'(1))) begin
            w_done     = 1'b1;
            w_res_line = w_cur_line;
            w_res_offs = n_byte_pos;
        end
        for (int k = 1; k < LV; k++) begin
            if (r_live[k] && w_hit[k] && (wtps_pkg::LEN_W'(k + 1) == w_len)) begin
                w_done     = 1'b1;
                w_res_line = r_att_line[k];
                w_res_offs = r_att_offs[k];
            end
        end
    end

    assign n_match_total  = (w_done && (r_match_total != COUNT_MAX))
                            ? r_match_total + 1'b1 : r_match_total;
    assign w_result       = {w_res_line, w_res_offs, n_match_total};

    // control state; end of text clears everything after the byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live        <= '0;
            r_byte_pos    <= '0;
            r_line_cnt    <= '0;
            r_match_total <= '0;
        end else if (r_in_valid) begin
            if (r_in_eot) begin
                r_live        <= '0;
                r_byte_pos    <= '0;
                r_line_cnt    <= '0;
                r_match_total <= '0;
            end else begin
                r_live        <= n_live;
                r_byte_pos    <= n_byte_pos;
                r_line_cnt    <= n_line_cnt;
                r_match_total <= n_match_total;
            end
        end
    end

    // attempt start data, read only while live
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_att_line <= n_att_line;
            r_att_offs <= n_att_offs;
        end
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    assign w_out_pop = o_out_valid && !i_out_stall;

    wtps_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_in_valid && w_done),
        .i_data   (w_result),
        .i_pop    (w_out_pop),
        .o_data   (w_fifo_data),
        .o_status (w_fifo_st)
    );

    assign o_out_valid      = w_fifo_st.not_empty;
    assign o_match_line     = w_fifo_data.line;
    assign o_match_offset   = w_fifo_data.offset;
    assign o_matches_so_far = w_fifo_data.total;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a result word never arrives at a full queue without a pop
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_done) |->
        ((w_fifo_st.count != wtps_pkg::FIFO_CNT_W'(wtps_pkg::FIFO_DEPTH)) || w_out_pop))
        else $error("result queue overflow");

    // end of text leaves no live attempt and cleared counters
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_eot) |=> ((r_live == '0) && (r_byte_pos == '0) &&
                                      (r_match_total == '0) && (r_line_cnt == '0)))
        else $error("state not cleared after end of text");

    // byte position saturates instead of wrapping
    a_pos_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_eot) |=> (r_byte_pos != '0))
        else $error("byte position wrapped");

    // a full queue always stalls the input
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fifo_st.count == wtps_pkg::FIFO_CNT_W'(wtps_pkg::FIFO_DEPTH)) |-> o_in_stall)
        else $error("input taken with full result queue");

endmodule

@@ verif/tb_whitespace_tolerant_pattern_search_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_whitespace_tolerant_pattern_search_unit
// Self-checking bench for the pattern search unit. Text words are streamed in
// from a queue with random gaps, and match words are taken with random
// stalls. A local model of the attempt trackers predicts each match word. The
// pattern is reprogrammed over APB between phases, only while nothing is in
// flight. Live attempts are carried across some of these changes.
// ----------------------------------------------------------------------------
module tb_whitespace_tolerant_pattern_search_unit;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int FLUSH_CYCLES    = 8;
    localparam int IDLE_TIMEOUT    = 20000;
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 62;
    localparam int RUN_LIMIT       = 400000 * CLK_PERIOD;

    localparam logic [wtps_pkg::OFFS_W-1:0] SAT32 = 32'hFFFF_FFFF;
    localparam logic [wtps_pkg::LINE_W-1:0] SAT24 = 24'hFF_FFFF;

    // one text word as queued for the driver
    typedef struct packed {
        logic [wtps_pkg::BYTE_W-1:0] text;
        logic                        last;
    } t_text_word;

    // DUT ports
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_in_valid    = 1'b0;
    logic                            o_in_stall;
    logic [wtps_pkg::BYTE_W-1:0]     i_text_byte   = '0;
    logic                            i_end_of_text = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall   = 1'b0;
    logic [wtps_pkg::LINE_W-1:0]     o_match_line;
    logic [wtps_pkg::OFFS_W-1:0]     o_match_offset;
    logic [wtps_pkg::COUNT_W-1:0]    o_matches_so_far;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [wtps_pkg::APB_ADDR_W-1:0] paddr         = '0;
    logic [wtps_pkg::APB_DATA_W-1:0] pwdata        = '0;
    logic [wtps_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // predictor copy of the registers
    logic [63:0]                cfg_pat_low  = '0;
    logic [63:0]                cfg_pat_high = '0;
    logic [wtps_pkg::LEN_W-1:0] cfg_pat_len  = 5'd1;

    // predictor copy of the search state
    logic                         att_live [wtps_pkg::LEVELS];
    logic [wtps_pkg::LINE_W-1:0]  att_line [wtps_pkg::LEVELS];
    logic [wtps_pkg::OFFS_W-1:0]  att_off  [wtps_pkg::LEVELS];
    logic                         nx_live  [wtps_pkg::LEVELS];
    logic [wtps_pkg::LINE_W-1:0]  nx_line  [wtps_pkg::LEVELS];
    logic [wtps_pkg::OFFS_W-1:0]  nx_off   [wtps_pkg::LEVELS];
    logic [wtps_pkg::OFFS_W-1:0]  text_pos;
    logic [wtps_pkg::LINE_W-1:0]  line_cnt;
    logic [wtps_pkg::COUNT_W-1:0] match_cnt;

    wtps_pkg::t_result match_expect [$];
    t_text_word        text_pending [$];

    int err_count    = 0;
    int in_idle_max  = 4;
    int out_idle_max = 4;
    int in_gap       = 0;
    int out_hold     = 0;

    // pattern length per random phase: extremes and out-of-range codes included
    logic [wtps_pkg::LEN_W-1:0] len_plan [RANDOM_PHASES] =
        '{5'd3, 5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd5, 5'd20, 5'd4, 5'd6, 5'd2, 5'd8};

    whitespace_tolerant_pattern_search_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_text_byte      (i_text_byte),
        .i_end_of_text    (i_end_of_text),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_line     (o_match_line),
        .o_match_offset   (o_match_offset),
        .o_matches_so_far (o_matches_so_far),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Search predictor
    // ------------------------------------------------------------------
    function automatic logic [wtps_pkg::BYTE_W-1:0] pattern_char(int idx);
        if (idx < 8)
            return cfg_pat_low[8*idx +: 8];
        return cfg_pat_high[8*(idx-8) +: 8];
    endfunction

    function automatic logic is_gap_char(logic [wtps_pkg::BYTE_W-1:0] c);
        return (c == wtps_pkg::CH_SPACE) || (c == wtps_pkg::CH_TAB) ||
               (c == wtps_pkg::CH_LF);
    endfunction

    function automatic int clamp_len(logic [wtps_pkg::LEN_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > wtps_pkg::MAX_PATTERN)
            return wtps_pkg::MAX_PATTERN;
        return int'(raw);
    endfunction

    // keep the attempt with the smaller start offset; first placed wins a tie
    function automatic void offer_attempt(int lvl, logic [wtps_pkg::LINE_W-1:0] ln,
                                          logic [wtps_pkg::OFFS_W-1:0] off);
        if (lvl >= wtps_pkg::LEVELS)
            return;
        if (nx_live[lvl] && nx_off[lvl] <= off)
            return;
        nx_live[lvl] = 1'b1;
        nx_line[lvl] = ln;
        nx_off[lvl]  = off;
    endfunction

    function automatic void clear_search_state();
        int k;
        for (k = 0; k < wtps_pkg::LEVELS; k++) begin
            att_live[k] = 1'b0;
            att_line[k] = '0;
            att_off[k]  = '0;
        end
        text_pos  = '0;
        line_cnt  = '0;
        match_cnt = '0;
    endfunction

    // advance the trackers by one text byte; queue the match word it yields
    function automatic void search_step(logic [wtps_pkg::BYTE_W-1:0] c, logic last);
        int                          len;
        int                          k;
        logic [wtps_pkg::OFFS_W-1:0] pos;
        logic [wtps_pkg::LINE_W-1:0] cur_line;
        logic                        hit;
        wtps_pkg::t_result           res;
        len      = clamp_len(cfg_pat_len);
        pos      = (text_pos == SAT32) ? SAT32 : text_pos + 32'd1;
        text_pos = pos;
        cur_line = (line_cnt >= SAT24) ? SAT24 : line_cnt + 24'd1;
        hit      = 1'b0;
        res      = '0;
        for (k = 0; k < wtps_pkg::LEVELS; k++) begin
            nx_live[k] = 1'b0;
            nx_line[k] = '0;
            nx_off[k]  = '0;
        end
        for (k = 1; k < len; k++) begin
            if (att_live[k]) begin
                if (c == pattern_char(k)) begin
                    if (k + 1 == len) begin
                        hit        = 1'b1;
                        res.line   = att_line[k];
                        res.offset = att_off[k];
                    end else begin
                        offer_attempt(k + 1, att_line[k], att_off[k]);
                    end
                end else if (is_gap_char(c)) begin
                    offer_attempt(k, att_line[k], att_off[k]);
                end
            end
        end
        // new attempt, or a line feed that starts none
        if (c == pattern_char(0)) begin
            if (len == 1) begin
                hit        = 1'b1;
                res.line   = cur_line;
                res.offset = pos;
            end else begin
                offer_attempt(1, cur_line, pos);
            end
        end else if (c == wtps_pkg::CH_LF) begin
            if (line_cnt < SAT24)
                line_cnt = line_cnt + 24'd1;
        end
        for (k = 0; k < wtps_pkg::LEVELS; k++) begin
            att_live[k] = nx_live[k];
            att_line[k] = nx_line[k];
            att_off[k]  = nx_off[k];
        end
        if (hit) begin
            if (match_cnt < SAT32)
                match_cnt = match_cnt + 32'd1;
            res.total = match_cnt;
            match_expect.push_back(res);
        end
        if (last)
            clear_search_state();
    endfunction

    // ------------------------------------------------------------------
    // Text driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : feed_text
        t_text_word word;
        logic       next_valid;
        next_valid = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                search_step(i_text_byte, i_end_of_text);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap != 0) begin
                    in_gap--;
                end else if (text_pending.size() != 0) begin
                    word          = text_pending.pop_front();
                    i_text_byte   <= word.text;
                    i_end_of_text <= word.last;
                    next_valid    = 1'b1;
                    in_gap        = $urandom_range(0, in_idle_max);
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // ------------------------------------------------------------------
    // Match monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_matches
        wtps_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (match_expect.size() == 0) begin
                $error("unexpected match word: line %0d offset %0d count %0d",
                       o_match_line, o_match_offset, o_matches_so_far);
                err_count++;
            end else begin
                want = match_expect.pop_front();
                if (o_match_line !== want.line) begin
                    $error("match_line: expected %0d, got %0d", want.line, o_match_line);
                    err_count++;
                end
                if (o_match_offset !== want.offset) begin
                    $error("match_offset: expected %0d, got %0d",
                           want.offset, o_match_offset);
                    err_count++;
                end
                if (o_matches_so_far !== want.total) begin
                    $error("matches_so_far: expected %0d, got %0d",
                           want.total, o_matches_so_far);
                    err_count++;
                end
            end
            out_hold = $urandom_range(0, out_idle_max);
        end else if (out_hold != 0) begin
            out_hold--;
        end
        i_out_stall <= (out_hold != 0);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_text(logic [wtps_pkg::BYTE_W-1:0] c, logic last);
        t_text_word w;
        w.text = c;
        w.last = last;
        text_pending.push_back(w);
    endtask

    function automatic logic draw_last();
        return ($urandom_range(0, 59) == 0);
    endfunction

    // APB write: setup, then access; predictor follows at the write edge
    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            wtps_pkg::REG_PAT_LOW:  cfg_pat_low  = val;
            wtps_pkg::REG_PAT_HIGH: cfg_pat_high = val;
            default:                cfg_pat_len  = val[wtps_pkg::LEN_W-1:0];
        endcase
    endtask

    // wait until every word is in and every match word is out, then flush
    task automatic wait_idle();
        int n;
        n = 0;
        @(negedge i_clk);
        while ((text_pending.size() != 0 || i_in_valid || match_expect.size() != 0)
               && n < IDLE_TIMEOUT) begin
            @(negedge i_clk);
            n++;
        end
        if (n >= IDLE_TIMEOUT) begin
            $error("search unit idle wait expired, %0d match words outstanding",
                   match_expect.size());
            err_count++;
        end
        repeat (FLUSH_CYCLES) @(negedge i_clk);
    endtask

    // mostly pattern instances with gaps, some broken, the rest noise
    task automatic queue_random_text(int count, logic [wtps_pkg::BYTE_W-1:0] letter);
        int                          made;
        int                          eff;
        int                          i;
        int                          g;
        int                          r;
        logic [wtps_pkg::BYTE_W-1:0] c;
        logic [wtps_pkg::BYTE_W-1:0] gaps [3];
        gaps[0] = wtps_pkg::CH_SPACE;
        gaps[1] = wtps_pkg::CH_TAB;
        gaps[2] = wtps_pkg::CH_LF;
        made    = 0;
        eff     = clamp_len(cfg_pat_len);
        while (made < count) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                for (i = 0; i < eff && made < count; i++) begin
                    if (i > 0 && $urandom_range(0, 3) == 0) begin
                        for (g = $urandom_range(1, 2); g > 0; g--) begin
                            push_text(gaps[$urandom_range(0, 2)], draw_last());
                            made++;
                        end
                    end
                    c = pattern_char(i);
                    if ($urandom_range(0, 11) == 0)
                        c = 8'($urandom_range(0, 255));
                    push_text(c, draw_last());
                    made++;
                end
            end else begin
                for (g = $urandom_range(1, 4); g > 0; g--) begin
                    case ($urandom_range(0, 2))
                        0:       c = 8'($urandom_range(0, 255));
                        1:       c = pattern_char($urandom_range(0, eff - 1));
                        default: c = letter;
                    endcase
                    push_text(c, draw_last());
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                          ph;
        int                          i;
        logic [wtps_pkg::BYTE_W-1:0] alpha [8];
        logic [wtps_pkg::BYTE_W-1:0] pat   [wtps_pkg::MAX_PATTERN];
        logic [63:0]                 lo;
        logic [63:0]                 hi;
        clear_search_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pattern: a single zero byte, reported at once
        push_text(8'h00, 1'b0);
        push_text(wtps_pkg::CH_LF, 1'b0);
        push_text(8'h00, 1'b1);
        wait_idle();

        // length code zero behaves as one
        reg_write(wtps_pkg::REG_PAT_LOW, 64'h0000_0000_0000_00FF);
        reg_write(wtps_pkg::REG_PAT_LEN, 64'd0);
        push_text(8'hFF, 1'b0);
        push_text(8'h00, 1'b1);
        wait_idle();

        // space, tab, 'x': competing attempts at one level, existing and new
        reg_write(wtps_pkg::REG_PAT_LOW,
                  {40'h0, 8'h78, wtps_pkg::CH_TAB, wtps_pkg::CH_SPACE});
        reg_write(wtps_pkg::REG_PAT_LEN, 64'd3);
        push_text(wtps_pkg::CH_SPACE, 1'b0);
        push_text(wtps_pkg::CH_SPACE, 1'b0);
        push_text(wtps_pkg::CH_TAB, 1'b0);
        push_text(wtps_pkg::CH_SPACE, 1'b0);
        push_text(wtps_pkg::CH_TAB, 1'b0);
        push_text(8'h78, 1'b1);
        wait_idle();

        // full sixteen bytes, length code above range, line feed inside
        reg_write(wtps_pkg::REG_PAT_LOW, 64'h0706_0504_0302_FF00);
        reg_write(wtps_pkg::REG_PAT_HIGH, 64'h8F8E_8D8C_8B8A_8988);
        reg_write(wtps_pkg::REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        for (i = 0; i < wtps_pkg::MAX_PATTERN; i++) begin
            push_text(pattern_char(i), i == wtps_pkg::MAX_PATTERN - 1);
            if (i == 3)
                push_text(wtps_pkg::CH_LF, 1'b0);
        end
        wait_idle();

        // random phases; live attempts survive into the next setting
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            in_idle_max  = (ph % 3 == 1) ? 0 : 4;
            out_idle_max = (ph % 4 == 2) ? 0 : 4;
            alpha[0] = 8'h61;
            alpha[1] = 8'h62;
            alpha[2] = wtps_pkg::CH_SPACE;
            alpha[3] = wtps_pkg::CH_TAB;
            alpha[4] = wtps_pkg::CH_LF;
            alpha[5] = 8'h00;
            alpha[6] = 8'hFF;
            alpha[7] = 8'($urandom_range(0, 255));
            for (i = 0; i < wtps_pkg::MAX_PATTERN; i++) begin
                if (i < clamp_len(len_plan[ph]))
                    pat[i] = alpha[$urandom_range(0, 7)];
                else
                    pat[i] = 8'($urandom_range(0, 255));
            end
            for (i = 0; i < 8; i++) begin
                lo[8*i +: 8] = pat[i];
                hi[8*i +: 8] = pat[i+8];
            end
            reg_write(wtps_pkg::REG_PAT_LOW, lo);
            reg_write(wtps_pkg::REG_PAT_HIGH, hi);
            reg_write(wtps_pkg::REG_PAT_LEN, {59'd0, len_plan[ph]});
            queue_random_text(WORDS_PER_PHASE, alpha[7]);
            wait_idle();
        end

        if (err_count == 0)
            $display("tb_whitespace_tolerant_pattern_search_unit: done, clean");
        else
            $display("tb_whitespace_tolerant_pattern_search_unit: done, errors");
        $finish;
    end

    // hard stop if the handshakes lock up
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("tb_whitespace_tolerant_pattern_search_unit: done, errors");
        $finish;
    end

endmodule
